FILE: hw/rtl/lsl_pkg.sv
// Types, constants and next-state functions of the link status LED pattern block.
`default_nettype none

package lsl_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_FAST = 2'd2
  } mode_t;

  // Timer owner, one-hot
  typedef enum logic [3:0] {
    OWN_BOOT   = 4'b0001,
    OWN_BLINK  = 4'b0010,
    OWN_DOUBLE = 4'b0100,
    OWN_IDLE   = 4'b1000
  } owner_t;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_PROFILE  = 2'd1;
  localparam logic [1:0] CMD_ENDPOINT = 2'd2;

  localparam logic [2:0] REG_SLOW_ON    = 3'd0;
  localparam logic [2:0] REG_SLOW_OFF   = 3'd1;
  localparam logic [2:0] REG_FAST_HALF  = 3'd2;
  localparam logic [2:0] REG_DOUBLE_ON  = 3'd3;
  localparam logic [2:0] REG_DOUBLE_OFF = 3'd4;
  localparam logic [2:0] REG_BOOT_ON    = 3'd5;
  localparam logic [2:0] REG_BOOT_OFF   = 3'd6;
  localparam logic [2:0] REG_BOOT_WAIT  = 3'd7;

  localparam logic [15:0] SLOW_ON_RST    = 16'd500;
  localparam logic [15:0] SLOW_OFF_RST   = 16'd1500;
  localparam logic [15:0] FAST_HALF_RST  = 16'd200;
  localparam logic [15:0] DOUBLE_ON_RST  = 16'd120;
  localparam logic [15:0] DOUBLE_OFF_RST = 16'd150;
  localparam logic [15:0] BOOT_ON_RST    = 16'd80;
  localparam logic [15:0] BOOT_OFF_RST   = 16'd100;
  localparam logic [15:0] BOOT_WAIT_RST  = 16'd500;

  localparam logic [2:0] DOUBLE_STEPS = 3'd4;
  localparam logic [2:0] BOOT_STEPS   = 3'd6;

  typedef struct packed {
    logic [15:0] slow_on;
    logic [15:0] slow_off;
    logic [15:0] fast_half;
    logic [15:0] double_on;
    logic [15:0] double_off;
    logic [15:0] boot_on;
    logic [15:0] boot_off;
    logic [15:0] boot_wait;
  } lsl_cfg_t;

  typedef struct packed {
    logic [2:0] prof;
    logic       is_last;
    logic       radio;
    logic       open;
    logic       conn;
  } lsl_item_t;

  typedef struct packed {
    logic        led;
    mode_t       mode;
    logic        npo;     // next blink phase is on
    logic        dact;    // double blink running
    logic        init;
    logic [2:0]  prev;
    logic [2:0]  dstep;
    logic [2:0]  bstep;
    logic [15:0] cnt;
    owner_t      own;
  } lsl_state_t;

  function automatic lsl_state_t blink_next(lsl_state_t s, lsl_cfg_t c);
    lsl_state_t r;
    r = s;
    if (s.mode == MODE_SLOW) begin
      r.cnt = s.npo ? c.slow_on : c.slow_off;
    end else begin
      r.cnt = c.fast_half;
    end
    r.led = s.npo;
    r.npo = ~s.npo;
    r.own = OWN_BLINK;
    return r;
  endfunction

  function automatic lsl_state_t change_mode(lsl_state_t s, mode_t m, lsl_cfg_t c);
    lsl_state_t r;
    r = s;
    if (!s.dact && m != s.mode) begin
      r.mode = m;
      r.npo  = 1'b1;
      r.own  = OWN_IDLE;
      if (m == MODE_OFF) begin
        r.led = 1'b0;
      end else begin
        r = blink_next(r, c);
      end
    end
    return r;
  endfunction

  function automatic lsl_state_t judge(lsl_state_t s, lsl_item_t it, lsl_cfg_t c);
    mode_t m;
    if (!it.radio || it.is_last) begin
      m = MODE_OFF;
    end else if (it.open) begin
      m = MODE_FAST;
    end else if (!it.conn) begin
      m = MODE_SLOW;
    end else begin
      m = MODE_OFF;
    end
    return change_mode(s, m, c);
  endfunction

  function automatic lsl_state_t double_next(lsl_state_t s, lsl_cfg_t c);
    lsl_state_t r;
    r = s;
    if (s.dstep >= DOUBLE_STEPS) begin
      r.dact = 1'b0;
      r.led  = 1'b0;
      r.mode = MODE_OFF;
      r.own  = OWN_IDLE;
    end else begin
      r.led   = ~s.dstep[0];
      r.cnt   = s.dstep[0] ? c.double_off : c.double_on;
      r.own   = OWN_DOUBLE;
      r.dstep = s.dstep + 3'd1;
    end
    return r;
  endfunction

  function automatic lsl_state_t start_double(lsl_state_t s, lsl_cfg_t c);
    lsl_state_t r;
    r       = s;
    r.dact  = 1'b1;
    r.dstep = 3'd0;
    r.mode  = MODE_OFF;
    return double_next(r, c);
  endfunction

  function automatic lsl_state_t boot_next(lsl_state_t s, lsl_item_t it, lsl_cfg_t c);
    lsl_state_t r;
    r = s;
    if (s.bstep < BOOT_STEPS) begin
      r.led   = ~s.bstep[0];
      r.cnt   = s.bstep[0] ? c.boot_off : c.boot_on;
      r.own   = OWN_BOOT;
      r.bstep = s.bstep + 3'd1;
    end else begin
      r.led  = 1'b0;
      r.own  = OWN_IDLE;
      r.prev = it.prof;
      r.init = 1'b1;
      if (it.is_last) begin
        r = start_double(r, c);
      end else begin
        r = judge(r, it, c);
      end
    end
    return r;
  endfunction

  function automatic lsl_state_t fire(lsl_state_t s, lsl_item_t it, lsl_cfg_t c);
    lsl_state_t r;
    r     = s;
    r.own = OWN_IDLE;
    case (s.own)
      OWN_BOOT:   r = boot_next(r, it, c);
      OWN_DOUBLE: r = double_next(r, c);
      OWN_BLINK: begin
        if (!r.dact && r.mode != MODE_OFF) begin
          r = blink_next(r, c);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic lsl_state_t lsl_step(lsl_state_t s, logic [1:0] cmd, lsl_item_t it,
                                          lsl_cfg_t c);
    lsl_state_t r;
    r = s;
    case (cmd)
      CMD_TICK: begin
        if (s.own != OWN_IDLE) begin
          if (s.cnt <= 16'd1) begin
            r = fire(s, it, c);
          end else begin
            r.cnt = s.cnt - 16'd1;
          end
        end
      end
      CMD_PROFILE: begin
        if (s.init && it.prof != s.prev && it.is_last) begin
          r = start_double(s, c);
        end else if (s.init && !s.dact) begin
          r = judge(s, it, c);
        end
        r.prev = it.prof;
      end
      CMD_ENDPOINT: begin
        if (s.init && !s.dact) begin
          r = judge(s, it, c);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/link_status_led_pattern.sv
// Link status LED pattern generator: top level with register file and result register.
`default_nettype none

// Takes one beat per clock while item_ready is high: a millisecond tick or a
// status event. The full pattern state (boot flash, blink, double blink, shared
// millisecond timer) is updated by logic between the state register and the
// result register, so a beat accepted at one edge has its result beat on the
// next. The result register frees as it is taken, so item_ready stays high while
// res_ready is high: one beat per cycle sustained. Durations must be programmed
// over the APB port while no beat is in flight; the block does not enforce it.
module link_status_led_pattern
  import lsl_pkg::*;
#(
  parameter int PROFILE_COUNT = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  profile,
  input  wire logic        link_is_radio,
  input  wire logic        profile_open,
  input  wire logic        profile_connected,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             led_lit,
  output logic      [1:0]  blink_mode,
  output logic             double_running,
  output logic             ready_res
);

  localparam logic [2:0] LastProfile = 3'(PROFILE_COUNT - 1);

  lsl_cfg_t   cfg;
  lsl_state_t state;
  lsl_state_t state_next;
  lsl_item_t  item;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       item_acc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_on    <= SLOW_ON_RST;
      cfg.slow_off   <= SLOW_OFF_RST;
      cfg.fast_half  <= FAST_HALF_RST;
      cfg.double_on  <= DOUBLE_ON_RST;
      cfg.double_off <= DOUBLE_OFF_RST;
      cfg.boot_on    <= BOOT_ON_RST;
      cfg.boot_off   <= BOOT_OFF_RST;
      cfg.boot_wait  <= BOOT_WAIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SLOW_ON:    cfg.slow_on    <= pwdata[15:0];
        REG_SLOW_OFF:   cfg.slow_off   <= pwdata[15:0];
        REG_FAST_HALF:  cfg.fast_half  <= pwdata[15:0];
        REG_DOUBLE_ON:  cfg.double_on  <= pwdata[15:0];
        REG_DOUBLE_OFF: cfg.double_off <= pwdata[15:0];
        REG_BOOT_ON:    cfg.boot_on    <= pwdata[15:0];
        REG_BOOT_OFF:   cfg.boot_off   <= pwdata[15:0];
        REG_BOOT_WAIT:  cfg.boot_wait  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (cfg_idx)
      REG_SLOW_ON:    prdata = {16'd0, cfg.slow_on};
      REG_SLOW_OFF:   prdata = {16'd0, cfg.slow_off};
      REG_FAST_HALF:  prdata = {16'd0, cfg.fast_half};
      REG_DOUBLE_ON:  prdata = {16'd0, cfg.double_on};
      REG_DOUBLE_OFF: prdata = {16'd0, cfg.double_off};
      REG_BOOT_ON:    prdata = {16'd0, cfg.boot_on};
      REG_BOOT_OFF:   prdata = {16'd0, cfg.boot_off};
      REG_BOOT_WAIT:  prdata = {16'd0, cfg.boot_wait};
      default:        prdata = 32'd0;
    endcase
  end

  assign item_ready = ~res_valid | res_ready;
  assign item_acc   = item_valid & item_ready;

  always_comb begin
    item.prof    = profile;
    item.is_last = (profile == LastProfile);
    item.radio   = link_is_radio;
    item.open    = profile_open;
    item.conn    = profile_connected;
    state_next   = lsl_step(state, cmd, item, cfg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.led   <= 1'b0;
      state.mode  <= MODE_OFF;
      state.npo   <= 1'b0;
      state.dact  <= 1'b0;
      state.init  <= 1'b0;
      state.prev  <= 3'd0;
      state.dstep <= 3'd0;
      state.bstep <= 3'd0;
      state.cnt   <= BOOT_WAIT_RST;
      state.own   <= OWN_BOOT;
    end else if (item_acc) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_acc) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      led_lit        <= state_next.led;
      blink_mode     <= state_next.mode;
      double_running <= state_next.dact;
      ready_res      <= state_next.init;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lsl_checker.sv
// Port-level checker for the link status LED pattern block, bound to the top level.
`default_nettype none

module lsl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       led_lit,
  input wire logic [1:0] blink_mode,
  input wire logic       double_running,
  input wire logic       ready_res
);

  // stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(led_lit) && $stable(blink_mode)
      && $stable(double_running) && $stable(ready_res))
    else $error("stalled result beat changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    item_ready == (!res_valid || res_ready))
    else $error("item_ready does not follow result register");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> res_valid)
    else $error("accepted beat produced no result");

  a_double_off: assert property (@(posedge clk) disable iff (rst)
    res_valid && double_running |-> blink_mode == 2'd0)
    else $error("blink mode set during double blink");

  a_boot_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !ready_res |-> !double_running && blink_mode == 2'd0)
    else $error("pattern active before boot flash finished");

endmodule

bind link_status_led_pattern lsl_checker u_lsl_checker (.*);

`default_nettype wire
